### rtl/nla_pkg.sv
`default_nettype none

package nla_pkg;

    localparam int MAX_LANDMARKS = 64;
    localparam int COORD_BITS    = 24;

    localparam int IDX_W  = (MAX_LANDMARKS > 1) ? $clog2(MAX_LANDMARKS) : 1;
    localparam int CNT_W  = $clog2(MAX_LANDMARKS + 1);
    localparam int OP_W   = 2;
    localparam int POS_W  = 7;
    localparam int DIST_W = 50;
    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // control from the sequencer to the distance unit
    typedef struct packed {
        logic             start;
        logic             issue;
        logic [CNT_W-1:0] pos;
    } scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] pos;
        logic [SQ_W-1:0]  sq_dist;
    } best_t;

endpackage

`default_nettype wire

### rtl/nla_if.sv
`default_nettype none

interface nla_cmd_if;
    import nla_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;

    modport source (output valid, output operation, output point_x, output point_y,
                    input ready);
    modport sink   (input valid, input operation, input point_x, input point_y,
                    output ready);
endinterface

interface nla_rsp_if;
    import nla_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [POS_W-1:0]  nearest_position;
    logic [DIST_W-1:0] distance_squared;

    modport source (output valid, output found, output nearest_position,
                    output distance_squared, input ready);
    modport sink   (input valid, input found, input nearest_position,
                    input distance_squared, output ready);
endinterface

`default_nettype wire

### rtl/nearest_landmark_association.sv
`default_nettype none

// channel   dir   payload                                           accepted
// cmd       in    operation, point_x, point_y                       valid & ready
// rsp       out   found, nearest_position, distance_squared         valid & ready
//
// landmarks sit in a ring of cells; a query rotates the ring once around, one
// landmark past the distance unit per cycle, then waits until the distance unit
// drains before the result is registered; clear and append do not leave idle
// rst_n empties the landmark set; cell contents are not reset
// cmd is ready only while no query is in progress; a waiting result does not stop
// clear or append items, and a later query holds its result until rsp is free

module nearest_landmark_association (
    input  wire logic clk,
    input  wire logic rst_n,
    nla_cmd_if.sink   cmd,
    nla_rsp_if.source rsp
);
    import nla_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_idx_next;
    point_t           query_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_found_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic [DIST_W-1:0] out_dist_reg;

    logic      accept;
    logic      load_out;
    logic      append;
    logic      shift;
    op_t       op;
    point_t    cmd_point;
    scan_ctl_t ctl;
    logic      busy;
    best_t     best;
    point_t    held [MAX_LANDMARKS];

    assign op        = op_t'(cmd.operation);
    assign cmd_point = '{x: cmd.point_x, y: cmd.point_y};
    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign append    = accept && (op == OP_APPEND) && (count_reg < CNT_W'(MAX_LANDMARKS));
    assign shift     = (state_reg == ST_SCAN);

    genvar i;
    generate
        for (i = 0; i < MAX_LANDMARKS; i++)
        begin : g_ring
            nla_cell u_cell (
                .clk       (clk),
                .load      (append && (count_reg[IDX_W-1:0] == IDX_W'(i))),
                .load_data (cmd_point),
                .shift     (shift),
                .shift_in  (held[(i + 1) % MAX_LANDMARKS]),
                .held      (held[i])
            );
        end
    endgenerate

    nla_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .query    (query_reg),
        .landmark (held[0]),
        .busy     (busy),
        .best     (best)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        load_out       = 1'b0;
        ctl.start      = 1'b0;
        ctl.issue      = (state_reg == ST_SCAN) && (CNT_W'(scan_idx_reg) < count_reg);
        ctl.pos        = CNT_W'(scan_idx_reg) + CNT_W'(1);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_APPEND:
                        begin
                            if (append)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_QUERY:
                        begin
                            ctl.start     = 1'b1;
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            count_next = count_reg;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                // after a full turn cell 0 again holds the first landmark
                if (scan_idx_reg == IDX_W'(MAX_LANDMARKS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            query_reg <= cmd_point;
        end
        if (load_out)
        begin
            out_found_reg <= best.found;
            out_pos_reg   <= POS_W'(best.pos);
            out_dist_reg  <= DIST_W'(best.sq_dist);
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.found            = out_found_reg;
    assign rsp.nearest_position = out_pos_reg;
    assign rsp.distance_squared = out_dist_reg;

endmodule

`default_nettype wire

### rtl/nla_cell.sv
`default_nettype none

module nla_cell (
    input  wire logic            clk,
    input  wire logic            load,
    input  wire nla_pkg::point_t load_data,
    input  wire logic            shift,
    input  wire nla_pkg::point_t shift_in,
    output nla_pkg::point_t      held
);
    import nla_pkg::*;

    point_t data_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
        else if (shift)
        begin
            data_reg <= shift_in;
        end
    end

    assign held = data_reg;

endmodule

`default_nettype wire

### rtl/nla_dist.sv
`default_nettype none

module nla_dist (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nla_pkg::scan_ctl_t ctl,
    input  wire nla_pkg::point_t    query,
    input  wire nla_pkg::point_t    landmark,
    output logic                    busy,
    output nla_pkg::best_t          best
);
    import nla_pkg::*;

    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [DIFF_W-1:0]        mag_x;
    logic [DIFF_W-1:0]        mag_y;
    logic [SQ_W-1:0]          sum;
    logic                     take;

    logic              a_valid_reg;
    logic [CNT_W-1:0]  a_pos_reg;
    logic [DIFF_W-1:0] mag_x_reg;
    logic [DIFF_W-1:0] mag_y_reg;
    logic              b_valid_reg;
    logic [CNT_W-1:0]  b_pos_reg;
    logic [SQ_W-1:0]   sq_x_reg;
    logic [SQ_W-1:0]   sq_y_reg;
    logic              best_found_reg;
    logic [CNT_W-1:0]  best_pos_reg;
    logic [SQ_W-1:0]   best_sq_reg;

    always_comb
    begin
        dx    = DIFF_W'(query.x) - DIFF_W'(landmark.x);
        dy    = DIFF_W'(query.y) - DIFF_W'(landmark.y);
        mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        // cannot overflow: each square is below 2^(SQ_W-2)
        sum   = sq_x_reg + sq_y_reg;
        // strict compare keeps the earliest landmark on a tie
        take  = b_valid_reg && (!best_found_reg || sum < best_sq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= ctl.issue;
            b_valid_reg <= a_valid_reg;
            if (ctl.start)
            begin
                best_found_reg <= 1'b0;
            end
            else if (take)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_pos_reg <= ctl.pos;
        mag_x_reg <= mag_x;
        mag_y_reg <= mag_y;
        b_pos_reg <= a_pos_reg;
        sq_x_reg  <= mag_x_reg * mag_x_reg;
        sq_y_reg  <= mag_y_reg * mag_y_reg;
        if (ctl.start)
        begin
            best_pos_reg <= '0;
            best_sq_reg  <= '0;
        end
        else if (take)
        begin
            best_pos_reg <= b_pos_reg;
            best_sq_reg  <= sum;
        end
    end

    assign busy = a_valid_reg | b_valid_reg;
    assign best = '{found: best_found_reg, pos: best_pos_reg, sq_dist: best_sq_reg};

endmodule

`default_nettype wire
